// ===== hdl/mmrd_pkg.sv =====
package mmrd_pkg;

  localparam int REGION_COUNT_DEF = 8;
  localparam int ADDR_W = 32;

  typedef enum logic [1:0] {
    FUNC_LOAD  = 2'd0,
    FUNC_READ  = 2'd1,
    FUNC_WRITE = 2'd2,
    FUNC_NOP   = 2'd3
  } func_t;

  typedef enum logic [2:0] {
    KIND_NONE    = 3'd0,
    KIND_RAM     = 3'd1,
    KIND_ROM     = 3'd2,
    KIND_WTC     = 3'd3,
    KIND_NOALLOC = 3'd4,
    KIND_FILE    = 3'd5,
    KIND_REG     = 3'd6,
    KIND_OTHER   = 3'd7
  } kind_t;

  typedef enum logic [2:0] {
    ACT_BUS = 3'd0,
    ACT_MRD = 3'd1,
    ACT_MWR = 3'd2,
    ACT_RRD = 3'd3,
    ACT_RWR = 3'd4,
    ACT_IGN = 3'd5
  } action_t;

  typedef enum logic [1:0] {
    OFS_ZERO = 2'd0,
    OFS_DIFF = 2'd1,
    OFS_MOD  = 2'd2,
    OFS_ADDR = 2'd3
  } ofs_sel_t;

  localparam logic [1:0] SIZE_BLOCK = 2'd3;

  typedef struct packed {
    logic [1:0]        func;
    logic [ADDR_W-1:0] addr;
    logic [1:0]        access_size;
    logic [31:0]       write_data;
    logic [2:0]        slot;
    logic [ADDR_W-1:0] entry_base;
    logic [ADDR_W-1:0] entry_end;
    logic [2:0]        entry_kind;
    logic [31:0]       entry_rom_length;
  } in_t;

  typedef struct packed {
    logic [2:0]        action;
    logic              handled;
    logic [2:0]        region_index;
    logic [ADDR_W-1:0] region_offset;
    logic [1:0]        size_out;
    logic [31:0]       data_out;
  } out_t;

endpackage

// ===== hdl/memory_map_region_decoder.sv =====
// Address region decoder. One transaction per cycle on both channels; a
// read or write transaction passes the input register, the decision
// register, then 32 restoring-remainder stages that compute the ROM wrap
// offset one bit per stage, and its result leaves the last stage. Load
// transactions update the region table as they leave the input register,
// so later accesses see them, and produce no result. Stalls on the output
// hold the whole pipeline.
module memory_map_region_decoder #(
  parameter int REGION_COUNT = mmrd_pkg::REGION_COUNT_DEF
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_ready,
  input  mmrd_pkg::in_t  in_data,
  output logic           out_valid,
  input  logic           out_ready,
  output mmrd_pkg::out_t out_data,
  input  logic           cfg_we,
  input  logic           cfg_wdata
);
  import mmrd_pkg::*;

  localparam int DIV_STAGES = ADDR_W;

  typedef struct packed {
    action_t           act;
    logic              hnd;
    logic [2:0]        idx;
    logic [1:0]        size;
    logic [31:0]       data;
    logic [ADDR_W-1:0] addr;
    logic [ADDR_W-1:0] diff;
    logic [ADDR_W-1:0] len;
    logic [ADDR_W-1:0] rem;
    logic [ADDR_W-1:0] quo;
    ofs_sel_t          sel;
  } dv_t;

  logic [ADDR_W-1:0] start_r [REGION_COUNT];
  logic [ADDR_W-1:0] limit_r [REGION_COUNT];
  logic [ADDR_W-1:0] len_r   [REGION_COUNT];
  kind_t             kind_r  [REGION_COUNT];
  logic              dev_r;

  logic en;
  logic s0_valid_r;
  in_t  s0_r;
  logic s1_valid_r;
  dv_t  s1_r;
  dv_t  s1_nxt;
  logic dv_valid_r [DIV_STAGES];
  dv_t  dv_r       [DIV_STAGES];

  function automatic dv_t div_step(dv_t d);
    dv_t         o;
    logic [32:0] t;
    o = d;
    t = {d.rem, d.quo[ADDR_W-1]};
    if (t >= {1'b0, d.len}) begin
      t = t - {1'b0, d.len};
    end
    o.rem = t[ADDR_W-1:0];
    o.quo = {d.quo[ADDR_W-2:0], 1'b0};
    return o;
  endfunction

  assign en       = !dv_valid_r[DIV_STAGES-1] || out_ready;
  assign in_ready = en;

  always_comb begin
    logic        stop;
    logic        found;
    logic        term;
    logic [2:0]  fidx;
    logic        from;
    logic [ADDR_W-1:0] fstart;
    logic [ADDR_W-1:0] flen;
    logic        hit;
    s1_nxt      = '0;
    s1_nxt.act  = ACT_BUS;
    s1_nxt.sel  = OFS_ZERO;
    s1_nxt.size = s0_r.access_size;
    s1_nxt.addr = s0_r.addr;
    s1_nxt.len  = '1;
    stop   = 1'b0;
    found  = 1'b0;
    term   = 1'b0;
    fidx   = '0;
    from   = 1'b0;
    fstart = '0;
    flen   = '1;
    if (s0_r.func == FUNC_READ) begin
      for (int i = 0; i < REGION_COUNT; i++) begin
        hit = (s0_r.addr >= start_r[i]) && (s0_r.addr < limit_r[i]);
        if (!stop) begin
          if (kind_r[i] == KIND_NONE) begin
            stop = 1'b1;
          end else if (hit) begin
            unique case (kind_r[i])
              KIND_RAM, KIND_WTC, KIND_NOALLOC, KIND_FILE, KIND_ROM: begin
                found  = 1'b1;
                fidx   = 3'(i);
                from   = (kind_r[i] == KIND_ROM);
                fstart = start_r[i];
                flen   = len_r[i];
              end
              KIND_REG: begin
                stop = 1'b1;
                term = 1'b1;
                if (dev_r) begin
                  s1_nxt.act = ACT_RRD;
                  s1_nxt.hnd = 1'b1;
                  s1_nxt.idx = 3'(i);
                  s1_nxt.sel = OFS_ADDR;
                end
              end
              default: begin
                stop = 1'b1;
                term = 1'b1;
              end
            endcase
          end
        end
      end
      if (!term && found && s0_r.access_size != SIZE_BLOCK) begin
        s1_nxt.act  = ACT_MRD;
        s1_nxt.hnd  = 1'b1;
        s1_nxt.idx  = fidx;
        s1_nxt.diff = fstart;
        s1_nxt.len  = flen;
        s1_nxt.sel  = from ? OFS_MOD : OFS_DIFF;
      end
    end else begin
      for (int i = 0; i < REGION_COUNT; i++) begin
        hit = (s0_r.addr >= start_r[i]) && (s0_r.addr < limit_r[i]);
        if (!stop) begin
          if (kind_r[i] == KIND_NONE) begin
            stop = 1'b1;
          end else if (hit) begin
            unique case (kind_r[i])
              KIND_ROM: begin
                stop        = 1'b1;
                s1_nxt.act  = ACT_IGN;
                s1_nxt.hnd  = 1'b1;
                s1_nxt.idx  = 3'(i);
                s1_nxt.diff = start_r[i];
                s1_nxt.sel  = OFS_DIFF;
              end
              KIND_RAM, KIND_WTC, KIND_NOALLOC, KIND_FILE: begin
                stop = 1'b1;
                if (s0_r.access_size != SIZE_BLOCK) begin
                  s1_nxt.act  = ACT_MWR;
                  s1_nxt.hnd  = (kind_r[i] != KIND_WTC);
                  s1_nxt.idx  = 3'(i);
                  s1_nxt.diff = start_r[i];
                  s1_nxt.sel  = OFS_DIFF;
                  s1_nxt.data = s0_r.write_data;
                end
              end
              KIND_REG: begin
                if (dev_r) begin
                  stop        = 1'b1;
                  s1_nxt.act  = ACT_RWR;
                  s1_nxt.hnd  = 1'b1;
                  s1_nxt.idx  = 3'(i);
                  s1_nxt.sel  = OFS_ADDR;
                  s1_nxt.data = s0_r.write_data;
                end
              end
              default: begin
              end
            endcase
          end
        end
      end
    end
  end

  // table and config
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dev_r <= 1'b1;
      for (int i = 0; i < REGION_COUNT; i++) begin
        kind_r[i] <= KIND_NONE;
      end
    end else begin
      if (cfg_we) begin
        dev_r <= cfg_wdata;
      end
      if (en && s0_valid_r && s0_r.func == FUNC_LOAD) begin
        for (int i = 0; i < REGION_COUNT; i++) begin
          if (32'(i) == {29'b0, s0_r.slot}) begin
            kind_r[i] <= kind_t'(s0_r.entry_kind);
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en && s0_valid_r && s0_r.func == FUNC_LOAD) begin
      for (int i = 0; i < REGION_COUNT; i++) begin
        if (32'(i) == {29'b0, s0_r.slot}) begin
          start_r[i] <= s0_r.entry_base;
          limit_r[i] <= s0_r.entry_end;
          len_r[i]   <= (s0_r.entry_rom_length == '0) ? 32'd1 : s0_r.entry_rom_length;
        end
      end
    end
  end

  // pipeline valids
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_valid_r <= 1'b0;
      s1_valid_r <= 1'b0;
      for (int k = 0; k < DIV_STAGES; k++) begin
        dv_valid_r[k] <= 1'b0;
      end
    end else if (en) begin
      s0_valid_r <= in_valid;
      s1_valid_r <= s0_valid_r &&
                    (s0_r.func == FUNC_READ || s0_r.func == FUNC_WRITE);
      dv_valid_r[0] <= s1_valid_r;
      for (int k = 1; k < DIV_STAGES; k++) begin
        dv_valid_r[k] <= dv_valid_r[k-1];
      end
    end
  end

  // pipeline payload
  always_ff @(posedge clk) begin
    dv_t d0;
    d0      = s1_r;
    d0.diff = s1_r.addr - s1_r.diff;
    d0.rem  = '0;
    d0.quo  = s1_r.addr - s1_r.diff;
    if (en) begin
      s0_r  <= in_data;
      s1_r  <= s1_nxt;
      dv_r[0] <= div_step(d0);
      for (int k = 1; k < DIV_STAGES; k++) begin
        dv_r[k] <= div_step(dv_r[k-1]);
      end
    end
  end

  always_comb begin
    dv_t d;
    d                      = dv_r[DIV_STAGES-1];
    out_valid              = dv_valid_r[DIV_STAGES-1];
    out_data.action        = d.act;
    out_data.handled       = d.hnd;
    out_data.region_index  = d.idx;
    out_data.size_out      = d.size;
    out_data.data_out      = d.data;
    unique case (d.sel)
      OFS_DIFF: out_data.region_offset = d.diff;
      OFS_MOD:  out_data.region_offset = d.rem;
      OFS_ADDR: out_data.region_offset = d.addr;
      default:  out_data.region_offset = '0;
    endcase
  end

endmodule

// ===== bench/tb.sv =====
module tb;
  import mmrd_pkg::*;

  localparam int SLOTS = REGION_COUNT_DEF;
  localparam int CYCLE_LIMIT = 600000;

  class region_scoreboard;
    logic [31:0] base_tab [SLOTS];
    logic [31:0] end_tab [SLOTS];
    logic [2:0] kind_tab [SLOTS];
    logic [31:0] wrap_tab [SLOTS];
    bit reg_dev;
    out_t pending[$];
    int mismatches;

    function new();
      for (int i = 0; i < SLOTS; i++) begin
        base_tab[i] = '0;
        end_tab[i] = '0;
        kind_tab[i] = KIND_NONE;
        wrap_tab[i] = '0;
      end
      reg_dev = 1'b1;
      mismatches = 0;
    endfunction

    function out_t bus_result(logic [1:0] sz);
      out_t r;
      r = '0;
      r.action = ACT_BUS;
      r.size_out = sz;
      return r;
    endfunction

    function out_t make(action_t a, bit h, int idx, logic [31:0] ofs, logic [1:0] sz,
                        logic [31:0] d);
      out_t r;
      r.action = a;
      r.handled = h;
      r.region_index = idx[2:0];
      r.region_offset = ofs;
      r.size_out = sz;
      r.data_out = d;
      return r;
    endfunction

    function out_t decode_read(in_t t);
      bit found;
      int idx;
      logic [31:0] ofs;
      logic [2:0] k;
      found = 0;
      idx = 0;
      ofs = '0;
      for (int i = 0; i < SLOTS; i++) begin
        k = kind_tab[i];
        if (k == KIND_NONE) break;
        if (!(t.addr >= base_tab[i] && t.addr < end_tab[i])) continue;
        case (k)
          KIND_RAM, KIND_WTC, KIND_NOALLOC, KIND_FILE: begin
            found = 1;
            idx = i;
            ofs = t.addr - base_tab[i];
          end
          KIND_ROM: begin
            found = 1;
            idx = i;
            ofs = (t.addr - base_tab[i]) % wrap_tab[i];
          end
          KIND_REG: begin
            if (reg_dev) return make(ACT_RRD, 1, i, t.addr, t.access_size, '0);
            return bus_result(t.access_size);
          end
          default: return bus_result(t.access_size);
        endcase
      end
      if (found && t.access_size != SIZE_BLOCK)
        return make(ACT_MRD, 1, idx, ofs, t.access_size, '0);
      return bus_result(t.access_size);
    endfunction

    function out_t decode_write(in_t t);
      logic [2:0] k;
      for (int i = 0; i < SLOTS; i++) begin
        k = kind_tab[i];
        if (k == KIND_NONE) break;
        if (!(t.addr >= base_tab[i] && t.addr < end_tab[i])) continue;
        if (k == KIND_ROM)
          return make(ACT_IGN, 1, i, t.addr - base_tab[i], t.access_size, '0);
        if (k == KIND_RAM || k == KIND_NOALLOC || k == KIND_FILE || k == KIND_WTC) begin
          if (t.access_size == SIZE_BLOCK) return bus_result(t.access_size);
          return make(ACT_MWR, k != KIND_WTC, i, t.addr - base_tab[i], t.access_size,
                      t.write_data);
        end
        if (k == KIND_REG && reg_dev)
          return make(ACT_RWR, 1, i, t.addr, t.access_size, t.write_data);
      end
      return bus_result(t.access_size);
    endfunction

    function void note_input(in_t t);
      case (t.func)
        FUNC_LOAD: begin
          base_tab[t.slot] = t.entry_base;
          end_tab[t.slot] = t.entry_end;
          kind_tab[t.slot] = t.entry_kind;
          wrap_tab[t.slot] = (t.entry_rom_length == 0) ? 32'd1 : t.entry_rom_length;
        end
        FUNC_READ: pending.push_back(decode_read(t));
        FUNC_WRITE: pending.push_back(decode_write(t));
        default: ;
      endcase
    endfunction

    function void check_result(out_t got);
      out_t e;
      if (pending.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %h", got);
        return;
      end
      e = pending.pop_front();
      if (got.action !== e.action || got.handled !== e.handled ||
          got.region_index !== e.region_index || got.region_offset !== e.region_offset ||
          got.size_out !== e.size_out || got.data_out !== e.data_out) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("mismatch: exp act=%0d h=%0d idx=%0d ofs=%h sz=%0d d=%h",
                   e.action, e.handled, e.region_index, e.region_offset, e.size_out,
                   e.data_out);
          $display("          got act=%0d h=%0d idx=%0d ofs=%h sz=%0d d=%h",
                   got.action, got.handled, got.region_index,
                   got.region_offset, got.size_out, got.data_out);
        end
      end
    endfunction
  endclass

  logic clk = 0;
  logic rst_n = 0;
  logic in_valid = 0;
  logic in_ready;
  in_t in_data = '0;
  logic out_valid;
  logic out_ready = 0;
  out_t out_data;
  logic cfg_we = 0;
  logic cfg_wdata = 0;

  region_scoreboard sb = new();
  int accepted = 0;
  int cycles = 0;
  int stall_left = 0;
  bit no_gaps = 0;
  logic [31:0] tb_base [SLOTS];
  logic [31:0] tb_span [SLOTS];

  memory_map_region_decoder u_top (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
    if (rst_n && in_valid && in_ready) begin
      sb.note_input(in_data);
      accepted++;
    end
    if (rst_n && out_valid && out_ready) sb.check_result(out_data);
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (no_gaps || r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  always @(negedge clk) begin
    if (stall_left > 0) begin
      stall_left--;
      out_ready <= 0;
    end else if (no_gaps) begin
      out_ready <= 1;
    end else begin
      stall_left = pick_gap();
      out_ready <= (stall_left == 0);
    end
  end

  task automatic send(in_t t);
    int g;
    int seen;
    g = pick_gap();
    if (g > 0) begin
      in_valid <= 0;
      repeat (g) @(negedge clk);
    end
    in_valid <= 1;
    in_data <= t;
    seen = accepted;
    do @(negedge clk); while (accepted == seen);
  endtask

  task automatic go_idle();
    in_valid <= 0;
    while (sb.pending.size() != 0) @(negedge clk);
    repeat (40) @(negedge clk);
  endtask

  task automatic write_cfg(bit v);
    cfg_we <= 1;
    cfg_wdata <= v;
    @(negedge clk);
    cfg_we <= 0;
    sb.reg_dev = v;
  endtask

  function automatic in_t rand_item();
    in_t t;
    t.func = $urandom_range(0, 3);
    t.addr = $urandom;
    t.access_size = $urandom_range(0, 3);
    t.write_data = $urandom;
    t.slot = $urandom_range(0, 7);
    t.entry_base = $urandom;
    t.entry_end = $urandom;
    t.entry_kind = $urandom_range(0, 7);
    t.entry_rom_length = $urandom;
    return t;
  endfunction

  function automatic in_t load_item(int s, logic [31:0] b, logic [31:0] e, kind_t k,
                                    logic [31:0] len);
    in_t t;
    t = rand_item();
    t.func = FUNC_LOAD;
    t.slot = s[2:0];
    t.entry_base = b;
    t.entry_end = e;
    t.entry_kind = k;
    t.entry_rom_length = len;
    return t;
  endfunction

  function automatic in_t access_item(func_t f, logic [31:0] a, logic [1:0] sz);
    in_t t;
    t = rand_item();
    t.func = f;
    t.addr = a;
    t.access_size = sz;
    return t;
  endfunction

  task automatic load_table();
    logic [31:0] win;
    logic [31:0] len;
    int r;
    kind_t k;
    r = $urandom_range(0, 3);
    win = (r == 0) ? 32'h0 : (r == 1) ? 32'hFFFF_FC00 : ($urandom & 32'hFFFF_F000);
    for (int i = 0; i < SLOTS; i++) begin
      r = $urandom_range(0, 99);
      if (r < 4) k = KIND_NONE;
      else if (r < 10) k = KIND_OTHER;
      else k = kind_t'($urandom_range(1, 6));
      tb_base[i] = win + $urandom_range(0, 511);
      tb_span[i] = $urandom_range(0, 400);
      r = $urandom_range(0, 9);
      len = (r == 0) ? 32'd0 : (r == 1) ? $urandom : $urandom_range(1, 300);
      send(load_item(i, tb_base[i], tb_base[i] + tb_span[i], k, len));
    end
  endtask

  task automatic run_phase(int n);
    int s;
    int r;
    logic [31:0] a;
    in_t t;
    for (int j = 0; j < n; j++) begin
      if (j % 50 == 0) no_gaps = ($urandom_range(0, 3) == 0);
      r = $urandom_range(0, 99);
      if (r < 4) begin
        t = rand_item();
        if (t.func == FUNC_LOAD) begin
          s = t.slot;
          if (t.entry_kind == KIND_NONE) t.entry_kind = KIND_RAM;
          tb_base[s] = t.entry_base;
          tb_span[s] = t.entry_end - t.entry_base;
        end
        send(t);
      end else begin
        s = $urandom_range(0, SLOTS - 1);
        a = (r < 85) ? tb_base[s] + $urandom_range(0, tb_span[s] + 2) - 1 : $urandom;
        send(access_item(($urandom_range(0, 1) == 0) ? FUNC_READ : FUNC_WRITE, a,
                         $urandom_range(0, 3)));
      end
    end
  endtask

  initial begin
    in_t t;
    repeat (4) @(negedge clk);
    rst_n <= 1;
    @(negedge clk);
    write_cfg(1);

    send(load_item(0, 32'h1000, 32'h2000, KIND_RAM, 32'h10));
    send(load_item(1, 32'h1800, 32'h3000, KIND_ROM, 32'h100));
    send(load_item(2, 32'h4000, 32'h5000, KIND_WTC, 32'h1));
    send(load_item(3, 32'h5000, 32'h6000, KIND_NOALLOC, 32'h1));
    send(load_item(4, 32'h6000, 32'h7000, KIND_FILE, 32'h1));
    send(load_item(5, 32'hF000_0000, 32'hFFFF_FFFF, KIND_REG, 32'hFFFF_FFFF));
    send(load_item(6, 32'h8000, 32'h9000, KIND_OTHER, 32'h1));
    send(load_item(7, 32'h0, 32'hFFFF_FFFF, KIND_ROM, 32'h0));
    send(access_item(FUNC_READ, 32'h1900, 2'd0));
    send(access_item(FUNC_READ, 32'h1900, SIZE_BLOCK));
    send(access_item(FUNC_WRITE, 32'h1900, 2'd2));
    send(access_item(FUNC_WRITE, 32'h4100, 2'd1));
    send(access_item(FUNC_WRITE, 32'h2100, 2'd1));
    send(access_item(FUNC_READ, 32'hF000_0010, 2'd2));
    send(access_item(FUNC_WRITE, 32'hF000_0010, SIZE_BLOCK));
    send(access_item(FUNC_READ, 32'h8100, 2'd0));
    send(access_item(FUNC_WRITE, 32'h8100, 2'd0));
    send(access_item(FUNC_READ, 32'h0, 2'd1));
    send(access_item(FUNC_READ, 32'hFFFF_FFFF, 2'd2));
    send(access_item(FUNC_WRITE, 32'hFFFF_FFFF, 2'd0));
    send(access_item(FUNC_WRITE, 32'h5000, SIZE_BLOCK));
    send(access_item(FUNC_READ, 32'h6FFF, 2'd0));
    t = rand_item();
    t.func = FUNC_NOP;
    send(t);

    for (int ph = 0; ph < 4; ph++) begin
      go_idle();
      write_cfg(ph[0] ? 1'b1 : 1'b0);
      load_table();
      run_phase(170);
    end

    go_idle();
    if (sb.mismatches == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end
endmodule
